// ===== hdl/tcw_pkg.sv =====
// Shared definitions for the text console cell writer: screen geometry,
// function codes, character constants and the item types of both channels.
// Depends on nothing; every file of the block refers to it by scoped names.
package tcw_pkg;

   localparam int COLS     = 80;
   localparam int ROWS     = 25;
   localparam int CELLS    = COLS * ROWS;
   localparam int IDX_W    = $clog2(CELLS);
   // Width of row * COLS + col for any row and col that the fields can carry.
   localparam int GIVEN_W  = $clog2(31 * COLS + 128);
   localparam int POS_W    = 11;
   localparam int CELL_W   = 16;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_ATTR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_ATTR   = 2'd1;

   localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;
   localparam logic [7:0] ERROR_ATTR_RESET   = 8'd244;

   localparam logic [2:0] FN_PUT   = 3'd0;
   localparam logic [2:0] FN_BACK  = 3'd1;
   localparam logic [2:0] FN_CLEAR = 3'd2;
   localparam logic [2:0] FN_SET   = 3'd3;
   localparam logic [2:0] FN_READ  = 3'd4;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_ERROR   = 8'd69;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] char_code;
      logic [7:0] attr;
      logic       use_position;
      logic [6:0] col;
      logic [4:0] row;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] cursor_pos;
      logic [7:0]       cell_char;
      logic [7:0]       cell_attr;
      logic             position_error;
      logic             scrolled;
   } rsp_type;

endpackage

// ===== hdl/text_console_cell_writer_unit.sv =====
// Top level of the text console cell writer: screen store, cursor, scroll
// logic and the request, response and register channels.
// Depends on tcw_pkg for geometry, function codes and item types.
//
// Usage: an item on req_data is taken when req_valid is high and req_stall is
// low; each item gives exactly one response on rsp_data, taken when rsp_valid
// is high and rsp_stall is low. Registers default_attr (index 0) and
// error_attr (index 1) are written over csr_valid/csr_ready, which is always
// ready; other indexes are ignored.
// The screen is a ring of rows in one single-port memory; a scroll moves the
// ring base by one row and clears the new bottom row.
// A newline searches for its column one row at a time, and a scroll and a
// screen clear write their cells one after another.
// After reset the memory is swept to zero, one cell a cycle,
// with req_stall high; register writes are taken during the sweep.
// A finished response waits in an output register: the next item is taken
// meanwhile, and its response is held back until the waiting one is taken.
module text_console_cell_writer_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tcw_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tcw_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                     csr_data
);

   localparam int COLS  = tcw_pkg::COLS;
   localparam int CELLS = tcw_pkg::CELLS;
   localparam int IW    = tcw_pkg::IDX_W;
   localparam int GW    = tcw_pkg::GIVEN_W;
   localparam int PW    = tcw_pkg::POS_W;
   localparam int CW    = tcw_pkg::CELL_W;

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_EXEC   = 4'd2;
   localparam logic [3:0] ST_PUT    = 4'd3;
   localparam logic [3:0] ST_NL     = 4'd4;
   localparam logic [3:0] ST_POST   = 4'd5;
   localparam logic [3:0] ST_SCROLL = 4'd6;
   localparam logic [3:0] ST_CLEAR  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0]       state_ff, state_in;
   tcw_pkg::req_type item_ff, item_in;
   logic [IW-1:0]    cursor_ff, cursor_in;
   logic [IW-1:0]    base_ff, base_in;
   logic [IW-1:0]    cnt_ff, cnt_in;
   logic [GW-1:0]    pos_ff, pos_in;
   logic [GW-1:0]    rem_ff, rem_in;
   logic             perr_ff, perr_in;
   logic             scr_ff, scr_in;
   logic             hit_ff, hit_in;
   logic [7:0]       dattr_ff, dattr_in;
   logic [7:0]       eattr_ff, eattr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0]    mem [CELLS];
   logic [CW-1:0]    rdata_ff;
   logic             mem_we, mem_re;
   logic [IW-1:0]    mem_addr;
   logic [CW-1:0]    mem_wdata;

   logic [GW-1:0]    given;
   logic             out_of_range;
   logic [7:0]       put_attr;
   logic [GW-1:0]    read_pos;

   // Logical cell index to its place in the ring of rows.
   function automatic logic [IW-1:0] phys(input logic [IW-1:0] p, input logic [IW-1:0] b);
      logic [IW:0] sum;
      sum = {1'b0, p} + {1'b0, b};
      if (sum >= (IW+1)'(CELLS)) begin
         sum = sum - (IW+1)'(CELLS);
      end
      return sum[IW-1:0];
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      given = GW'(item_ff.row) * GW'(COLS) + GW'(item_ff.col);
      out_of_range = (int'(item_ff.col) >= COLS) || (int'(item_ff.row) >= tcw_pkg::ROWS);
      put_attr = (item_ff.attr == 8'd0) ? dattr_ff : item_ff.attr;
      read_pos = item_ff.use_position ? given : GW'(cursor_ff);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cursor_in    = cursor_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      perr_in      = perr_ff;
      scr_in       = scr_ff;
      hit_in       = hit_ff;
      dattr_in     = dattr_ff;
      eattr_in     = eattr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = '0;

      if (csr_valid) begin
         case (csr_index)
            tcw_pkg::CSR_DEFAULT_ATTR: dattr_in = csr_data;
            tcw_pkg::CSR_ERROR_ATTR:   eattr_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            mem_we   = 1'b1;
            mem_addr = cnt_ff;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == IW'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               perr_in  = 1'b0;
               scr_in   = 1'b0;
               hit_in   = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (item_ff.func)
               tcw_pkg::FN_PUT: begin
                  if (item_ff.use_position && out_of_range) begin
                     perr_in   = 1'b1;
                     mem_we    = 1'b1;
                     mem_addr  = phys(IW'(CELLS - 1), base_ff);
                     mem_wdata = {eattr_ff, tcw_pkg::CH_ERROR};
                  end
                  pos_in   = read_pos;
                  state_in = ST_PUT;
               end
               tcw_pkg::FN_BACK: begin
                  if (cursor_ff != '0) begin
                     cursor_in = cursor_ff - 1'b1;
                     mem_we    = 1'b1;
                     mem_addr  = phys(cursor_ff - 1'b1, base_ff);
                     mem_wdata = {dattr_ff, tcw_pkg::CH_SPACE};
                  end
               end
               tcw_pkg::FN_CLEAR: begin
                  cursor_in = '0;
                  cnt_in    = '0;
                  state_in  = ST_CLEAR;
               end
               tcw_pkg::FN_SET: begin
                  if (given < GW'(CELLS)) begin
                     cursor_in = IW'(given);
                  end
               end
               tcw_pkg::FN_READ: begin
                  if (read_pos < GW'(CELLS)) begin
                     mem_re   = 1'b1;
                     mem_addr = phys(IW'(read_pos), base_ff);
                     hit_in   = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_PUT: begin
            if (pos_ff >= GW'(CELLS)) begin
               state_in = ST_DONE;
            end else if (item_ff.char_code == tcw_pkg::CH_NEWLINE) begin
               rem_in   = pos_ff;
               state_in = ST_NL;
            end else begin
               mem_we    = 1'b1;
               mem_addr  = phys(IW'(pos_ff), base_ff);
               mem_wdata = {put_attr, item_ff.char_code};
               pos_in    = pos_ff + 1'b1;
               state_in  = ST_POST;
            end
         end
         ST_NL: begin
            // One row a cycle until the column within the row is left.
            if (rem_ff >= GW'(COLS)) begin
               rem_in = rem_ff - GW'(COLS);
            end else begin
               pos_in   = pos_ff - rem_ff + GW'(COLS);
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (pos_ff >= GW'(CELLS)) begin
               cursor_in = IW'(pos_ff - GW'(COLS));
               scr_in    = 1'b1;
               cnt_in    = '0;
               state_in  = ST_SCROLL;
            end else begin
               cursor_in = IW'(pos_ff);
               state_in  = ST_DONE;
            end
         end
         ST_SCROLL: begin
            // The top row of the ring becomes the new, blank bottom row.
            mem_we   = 1'b1;
            mem_addr = base_ff + cnt_ff;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == IW'(COLS - 1)) begin
               cnt_in   = '0;
               base_in  = (base_ff == IW'(CELLS - COLS)) ? '0 : base_ff + IW'(COLS);
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = cnt_ff;
            mem_wdata = {dattr_ff, tcw_pkg::CH_SPACE};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == IW'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_in.cursor_pos     = PW'(cursor_ff);
               rsp_in.cell_char      = hit_ff ? rdata_ff[7:0] : 8'd0;
               rsp_in.cell_attr      = hit_ff ? rdata_ff[15:8] : 8'd0;
               rsp_in.position_error = perr_ff;
               rsp_in.scrolled       = scr_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cursor_ff    <= '0;
         base_ff      <= '0;
         cnt_ff       <= '0;
         perr_ff      <= 1'b0;
         scr_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         dattr_ff     <= tcw_pkg::DEFAULT_ATTR_RESET;
         eattr_ff     <= tcw_pkg::ERROR_ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         base_ff      <= base_in;
         cnt_ff       <= cnt_in;
         perr_ff      <= perr_in;
         scr_ff       <= scr_in;
         hit_ff       <= hit_in;
         dattr_ff     <= dattr_in;
         eattr_ff     <= eattr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      pos_ff  <= pos_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_console_cell_writer_unit: a queue-fed driver
// that keeps a screen model, a checking monitor, and register writes between phases.
// Depends on tcw_pkg for geometry, function codes and the item types.
module testbench;

   // Function codes that the block treats as no operation.
   localparam logic [2:0] FN_NOP_FIRST = 3'd5;
   localparam logic [2:0] FN_NOP_LAST  = 3'd7;
   localparam int RANDOM_PER_PHASE = 130;
   localparam int HOLD_AT          = 45;
   localparam int HOLD_CYCLES      = 400;
   localparam int SETTLE_CYCLES    = 100;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   tcw_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   tcw_pkg::rsp_type              rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [tcw_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]                    csr_data = '0;

   // Model of the block's state, updated as items and register writes are taken.
   logic [tcw_pkg::CELL_W-1:0] screen [tcw_pkg::CELLS];
   int                         cursor;
   logic [7:0]                 def_attr;
   logic [7:0]                 err_attr;

   tcw_pkg::req_type items_to_send [$];
   tcw_pkg::rsp_type results_due [$];
   tcw_pkg::rsp_type want;
   int      items_taken = 0;
   int      hold_left = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      fail_count = 0;
   longint  cycle_count = 0;
   longint  cycle_budget = 4 * (tcw_pkg::CELLS + 1000 + HOLD_CYCLES);

   text_console_cell_writer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic tcw_pkg::rsp_type apply_console_op(tcw_pkg::req_type op);
      int               given;
      int               pos;
      logic [7:0]       at;
      tcw_pkg::rsp_type res;
      res = '0;
      given = int'(op.row) * tcw_pkg::COLS + int'(op.col);
      case (op.func)
         tcw_pkg::FN_PUT: begin
            at = (op.attr == 8'd0) ? def_attr : op.attr;
            if (op.use_position &&
                (int'(op.col) >= tcw_pkg::COLS || int'(op.row) >= tcw_pkg::ROWS)) begin
               screen[tcw_pkg::CELLS-1] = {err_attr, tcw_pkg::CH_ERROR};
               res.position_error = 1'b1;
            end
            pos = op.use_position ? given : cursor;
            // A position past the screen drops the character entirely.
            if (pos < tcw_pkg::CELLS) begin
               if (op.char_code == tcw_pkg::CH_NEWLINE) begin
                  pos = (pos / tcw_pkg::COLS + 1) * tcw_pkg::COLS;
               end else begin
                  screen[pos] = {at, op.char_code};
                  pos++;
               end
               if (pos >= tcw_pkg::CELLS) begin
                  for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLS; i++)
                     screen[i] = screen[i + tcw_pkg::COLS];
                  for (int i = tcw_pkg::CELLS - tcw_pkg::COLS; i < tcw_pkg::CELLS; i++)
                     screen[i] = '0;
                  pos -= tcw_pkg::COLS;
                  res.scrolled = 1'b1;
               end
               cursor = pos;
            end
         end
         tcw_pkg::FN_BACK: begin
            if (cursor > 0 && cursor <= tcw_pkg::CELLS) begin
               cursor--;
               screen[cursor] = {def_attr, tcw_pkg::CH_SPACE};
            end
         end
         tcw_pkg::FN_CLEAR: begin
            for (int i = 0; i < tcw_pkg::CELLS; i++) screen[i] = {def_attr, tcw_pkg::CH_SPACE};
            cursor = 0;
         end
         tcw_pkg::FN_SET: begin
            if (given < tcw_pkg::CELLS) cursor = given;
         end
         tcw_pkg::FN_READ: begin
            pos = op.use_position ? given : cursor;
            if (pos < tcw_pkg::CELLS) begin
               res.cell_char = screen[pos][7:0];
               res.cell_attr = screen[pos][15:8];
            end
         end
         default: ;
      endcase
      res.cursor_pos = tcw_pkg::POS_W'(cursor);
      return res;
   endfunction

   function automatic tcw_pkg::req_type console_op(logic [2:0] f, logic [7:0] ch,
                                                   logic [7:0] at, logic up,
                                                   logic [6:0] c, logic [4:0] r);
      tcw_pkg::req_type op;
      op.func = f;
      op.char_code = ch;
      op.attr = at;
      op.use_position = up;
      op.col = c;
      op.row = r;
      return op;
   endfunction

   // Mostly puts that drive the cursor towards the bottom row, so that scrolls,
   // out-of-range positions and backspaces over row boundaries come up often.
   function automatic tcw_pkg::req_type random_op();
      tcw_pkg::req_type op;
      int               pick;
      op = tcw_pkg::req_type'($urandom);
      pick = $urandom_range(99);
      if (pick < 40) begin
         op.func = tcw_pkg::FN_PUT;
         op.use_position = 1'b0;
         if ($urandom_range(99) < 15) op.char_code = tcw_pkg::CH_NEWLINE;
         if ($urandom_range(99) < 20) op.attr = 8'd0;
      end else if (pick < 55) begin
         op.func = tcw_pkg::FN_PUT;
         op.use_position = 1'b1;
         if ($urandom_range(99) < 10) op.char_code = tcw_pkg::CH_NEWLINE;
         case ($urandom_range(3))
            0: ;
            1: begin
               op.row = 5'(tcw_pkg::ROWS - 1);
               op.col = 7'($urandom_range(tcw_pkg::COLS - 1));
            end
            2: begin
               op.col = 7'(tcw_pkg::COLS - 1);
               op.row = 5'($urandom_range(tcw_pkg::ROWS - 1));
            end
            default: begin
               op.col = 7'($urandom_range(tcw_pkg::COLS - 1));
               op.row = 5'($urandom_range(tcw_pkg::ROWS - 1));
            end
         endcase
      end else if (pick < 65) begin
         op.func = tcw_pkg::FN_SET;
         if ($urandom_range(1) == 0) op.row = 5'(tcw_pkg::ROWS - 1);
      end else if (pick < 77) begin
         op.func = tcw_pkg::FN_BACK;
      end else if (pick < 93) begin
         op.func = tcw_pkg::FN_READ;
         if ($urandom_range(1) == 0) op.row = 5'($urandom_range(tcw_pkg::ROWS - 1));
      end else if (pick < 95) begin
         op.func = tcw_pkg::FN_CLEAR;
      end else begin
         op.func = 3'($urandom_range(FN_NOP_FIRST, FN_NOP_LAST));
      end
      return op;
   endfunction

   task automatic queue_item(tcw_pkg::req_type op);
      items_to_send.push_back(op);
      cycle_budget += 4 * ((op.func == tcw_pkg::FN_CLEAR ? tcw_pkg::CELLS + 3 :
                            5 + tcw_pkg::ROWS + tcw_pkg::COLS) + 120);
   endtask

   // Checked at the falling edge, when the driver's updates have all settled.
   task automatic wait_drained();
      while (items_to_send.size() != 0 || req_valid || results_due.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
      cycle_budget += 1000;
   endtask

   task automatic csr_write(logic [tcw_pkg::CSR_IDX_W-1:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == tcw_pkg::CSR_DEFAULT_ATTR) def_attr = value;
      else if (idx == tcw_pkg::CSR_ERROR_ATTR) err_attr = value;
   endtask

   // Driver: a new item is offered only once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            results_due.push_back(apply_console_op(req_data));
            items_taken <= items_taken + 1;
         end
         if (req_valid && req_stall) begin
         end else if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= items_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // One long hold-off on the result side while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (req_valid && !req_stall && items_taken == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $error("result item arrived with none outstanding");
               fail_count++;
            end else begin
               want = results_due.pop_front();
               if (rsp_data.cursor_pos !== want.cursor_pos) begin
                  $error("cursor_pos: expected %0d, actual %0d",
                         want.cursor_pos, rsp_data.cursor_pos);
                  fail_count++;
               end
               if (rsp_data.cell_char !== want.cell_char) begin
                  $error("cell_char: expected %0d, actual %0d",
                         want.cell_char, rsp_data.cell_char);
                  fail_count++;
               end
               if (rsp_data.cell_attr !== want.cell_attr) begin
                  $error("cell_attr: expected %0d, actual %0d",
                         want.cell_attr, rsp_data.cell_attr);
                  fail_count++;
               end
               if (rsp_data.position_error !== want.position_error) begin
                  $error("position_error: expected %0d, actual %0d",
                         want.position_error, rsp_data.position_error);
                  fail_count++;
               end
               if (rsp_data.scrolled !== want.scrolled) begin
                  $error("scrolled: expected %0d, actual %0d",
                         want.scrolled, rsp_data.scrolled);
                  fail_count++;
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_budget) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < tcw_pkg::CELLS; i++) screen[i] = '0;
      cursor = 0;
      def_attr = tcw_pkg::DEFAULT_ATTR_RESET;
      err_attr = tcw_pkg::ERROR_ATTR_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 76;
      // Directed items with the reset register values.
      queue_item(console_op(tcw_pkg::FN_READ, 8'd0, 8'd0, 1'b0, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_PUT, 8'h41, 8'd0, 1'b0, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_PUT, 8'hFF, 8'hFF, 1'b0, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_PUT, 8'd0, 8'd1, 1'b1, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_PUT, tcw_pkg::CH_NEWLINE, 8'd0, 1'b0, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_PUT, 8'h58, 8'h21, 1'b1, 7'd127, 5'd31));
      queue_item(console_op(tcw_pkg::FN_PUT, 8'h59, 8'h22, 1'b1, 7'd100, 5'd0));
      queue_item(console_op(tcw_pkg::FN_PUT, tcw_pkg::CH_NEWLINE, 8'h23, 1'b1, 7'd0, 5'd25));
      queue_item(console_op(tcw_pkg::FN_READ, 8'd0, 8'd0, 1'b1, 7'd79, 5'd24));
      queue_item(console_op(tcw_pkg::FN_SET, 8'd0, 8'd0, 1'b1, 7'd79, 5'd24));
      queue_item(console_op(tcw_pkg::FN_PUT, 8'h5A, 8'h80, 1'b0, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_PUT, tcw_pkg::CH_NEWLINE, 8'd0, 1'b1, 7'd5, 5'd24));
      queue_item(console_op(tcw_pkg::FN_SET, 8'd0, 8'd0, 1'b1, 7'd127, 5'd31));
      queue_item(console_op(tcw_pkg::FN_SET, 8'd0, 8'd0, 1'b1, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_BACK, 8'd0, 8'd0, 1'b0, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_SET, 8'd0, 8'd0, 1'b0, 7'd0, 5'd1));
      queue_item(console_op(tcw_pkg::FN_BACK, 8'd0, 8'd0, 1'b0, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_READ, 8'd0, 8'd0, 1'b0, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_READ, 8'd0, 8'd0, 1'b1, 7'd127, 5'd31));
      queue_item(console_op(tcw_pkg::FN_READ, 8'd0, 8'd0, 1'b1, 7'd127, 5'd0));
      queue_item(console_op(tcw_pkg::FN_CLEAR, 8'd0, 8'd0, 1'b0, 7'd0, 5'd0));
      queue_item(console_op(tcw_pkg::FN_READ, 8'd0, 8'd0, 1'b1, 7'd0, 5'd24));
      queue_item(console_op(tcw_pkg::FN_SET, 8'd0, 8'd0, 1'b0, 7'd10, 5'd2));
      for (int f = FN_NOP_FIRST; f <= FN_NOP_LAST; f++)
         queue_item(console_op(3'(f), 8'hAA, 8'h55, 1'b1, 7'd3, 5'd4));
      wait_drained();

      csr_write(tcw_pkg::CSR_DEFAULT_ATTR, 8'd0);
      csr_write(tcw_pkg::CSR_ERROR_ATTR, 8'hFF);
      repeat (RANDOM_PER_PHASE) queue_item(random_op());
      wait_drained();

      send_idle_pct = 76;
      recv_idle_pct = 30;
      csr_write(tcw_pkg::CSR_DEFAULT_ATTR, 8'hFF);
      csr_write(tcw_pkg::CSR_ERROR_ATTR, 8'd0);
      repeat (RANDOM_PER_PHASE) queue_item(random_op());
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(tcw_pkg::CSR_DEFAULT_ATTR, 8'($urandom_range(255)));
      csr_write(tcw_pkg::CSR_ERROR_ATTR, 8'($urandom_range(255)));
      repeat (RANDOM_PER_PHASE) queue_item(random_op());
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/tcw_pkg.sv
hdl/text_console_cell_writer_unit.sv
tb/testbench.sv
